// ----- rtl/core/qpc_pkg.sv -----
package qpc_pkg;

  localparam int unsigned DET_W     = 32;
  localparam int unsigned CHG_W     = 33;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned MAG_W     = 4;
  localparam int unsigned STEPS_W   = 8;
  localparam int unsigned RAW_W     = 41;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned MUL_STEPS = STEPS_W;
  localparam int unsigned DIV_STEPS = RAW_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DETENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DETENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 3'd4;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd4;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MUL_LO,
    S_MUL_HI,
    S_MOVE,
    S_LOAD,
    S_DIV_GO,
    S_DIV
  } state_e;

  localparam logic signed [1:0] DIR_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  function automatic logic [MAG_W-1:0] accel_mag(input logic enable,
                                                 input logic [TIME_W-1:0] gap);
    logic [MAG_W-1:0] mag;
    if (!enable) begin
      mag = 4'd1;
    end else if (gap < 32'd30) begin
      mag = 4'd10;
    end else if (gap < 32'd50) begin
      mag = 4'd7;
    end else if (gap < 32'd80) begin
      mag = 4'd5;
    end else if (gap < 32'd120) begin
      mag = 4'd3;
    end else if (gap < 32'd180) begin
      mag = 4'd2;
    end else begin
      mag = 4'd1;
    end
    return mag;
  endfunction

endpackage

// ----- rtl/core/qpc_arith.sv -----
module qpc_arith import qpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  arith_req_t              req_i,
  input  logic signed [RAW_W-1:0] opnd_i,
  input  logic [STEPS_W-1:0]      steps_i,
  output logic                    done_o,
  output logic signed [RAW_W-1:0] result_o
);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  arith_op_e               op_q, op_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [RAW_W-1:0] acc_q, acc_d;
  logic [RAW_W-1:0]        opnd_q, opnd_d;
  logic [STEPS_W-1:0]      rem_q, rem_d;
  logic [STEPS_W-1:0]      mult_q, mult_d;
  logic                    neg_q, neg_d;

  logic [STEPS_W:0]        trial;
  logic [STEPS_W:0]        diff;
  logic                    fits;
  logic [CNT_W-1:0]        last;

  assign trial = {rem_q, opnd_q[RAW_W-1]};
  assign diff  = trial - {1'b0, steps_i};
  assign fits  = (trial >= {1'b0, steps_i});
  assign last  = (op_q == OP_MUL) ? MUL_LAST : DIV_LAST;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opnd_d = opnd_q;
    rem_d  = rem_q;
    mult_d = mult_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      acc_d  = '0;
      rem_d  = '0;
      mult_d = steps_i;
      if (req_i.op == OP_MUL) begin
        opnd_d = opnd_i;
        neg_d  = 1'b0;
      end else begin
        neg_d  = opnd_i[RAW_W-1];
        opnd_d = opnd_i[RAW_W-1] ? -opnd_i : opnd_i;
      end
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        if (mult_q[0]) begin
          acc_d = acc_q + opnd_q;
        end
        opnd_d = {opnd_q[RAW_W-2:0], 1'b0};
        mult_d = {1'b0, mult_q[STEPS_W-1:1]};
      end else begin
        rem_d  = fits ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
        opnd_d = {opnd_q[RAW_W-2:0], fits};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    rem_q  <= rem_d;
    mult_q <= mult_d;
    neg_q  <= neg_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == OP_MUL) ? acc_q :
                    (neg_q ? -$signed(opnd_q) : $signed(opnd_q));

endmodule

// ----- rtl/core/quadrature_position_counter.sv -----
// Quadrature position counter with speed-dependent acceleration. Each input word
// carries a command: a pin sample that decodes the A/B transition and moves the raw
// count (wrapping or clamping at the bounds scaled by steps per detent), a read of the
// detent change since the previous read, a position load, or a position clear. Every
// word returns one result word with the detent position, the change and the raw step
// applied. One shared serial unit does the bound and load multiplications and the
// detent division. The block takes no new word while one is in work, but accepts the
// next word while one finished result waits in the output register; it takes none
// while a second finished result is still pending behind that one.
module quadrature_position_counter import qpc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DET_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic                     pin_a_i,
  input  logic                     pin_b_i,
  input  logic [TIME_W-1:0]        time_ms_i,
  input  logic signed [DET_W-1:0]  load_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DET_W-1:0]  detent_position_o,
  output logic signed [CHG_W-1:0]  change_o,
  output logic signed [STEP_W-1:0] step_applied_o
);

  state_e state_q, state_d;

  logic signed [DET_W-1:0]  min_q, max_q;
  logic                     wrap_q, accel_q;
  logic [STEPS_W-1:0]       steps_q;

  cmd_e                     cmd_q, cmd_d;
  logic [1:0]               prior_ab_q, prior_ab_d;
  logic signed [RAW_W-1:0]  raw_q, raw_d;
  logic signed [DET_W-1:0]  last_read_q, last_read_d;
  logic [TIME_W-1:0]        last_move_q, last_move_d;
  logic signed [STEP_W-1:0] step_q, step_d;
  logic                     moving_q, moving_d;
  logic signed [DET_W-1:0]  load_q, load_d;
  logic signed [RAW_W-1:0]  lo_q, lo_d;
  logic signed [RAW_W-1:0]  hi_q, hi_d;
  logic signed [DET_W-1:0]  det_w_q, det_w_d;
  logic signed [CHG_W-1:0]  chg_w_q, chg_w_d;
  logic                     res_pend_q, res_pend_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DET_W-1:0]  det_o_q, det_o_d;
  logic signed [CHG_W-1:0]  chg_o_q, chg_o_d;
  logic signed [STEP_W-1:0] step_o_q, step_o_d;

  logic                     accept;
  logic [STEPS_W-1:0]       s_eff;
  logic signed [1:0]        dir;
  logic [TIME_W-1:0]        gap;
  logic [MAG_W-1:0]         mag;
  logic signed [STEP_W-1:0] step_new;
  logic signed [RAW_W-1:0]  next_raw;
  logic signed [DET_W-1:0]  det_new;
  logic                     out_free;

  arith_req_t               areq;
  logic signed [RAW_W-1:0]  a_opnd;
  logic                     a_done;
  logic signed [RAW_W-1:0]  a_result;

  qpc_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (areq),
    .opnd_i   (a_opnd),
    .steps_i  (s_eff),
    .done_o   (a_done),
    .result_o (a_result)
  );

  assign in_ready_o = (state_q == S_IDLE) && !res_pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign s_eff    = (steps_q == '0) ? STEPS_W'(1) : steps_q;
  assign dir      = DIR_TABLE[{prior_ab_q, pin_b_i, pin_a_i}];
  assign gap      = time_ms_i - last_move_q;
  assign mag      = accel_mag(accel_q, gap);
  assign step_new = dir[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign next_raw = raw_q + RAW_W'(step_q);
  assign det_new  = a_result[DET_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (moving_q) begin
          state_d = S_MUL_LO;
        end else if (cmd_q == CMD_LOAD) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_DIV_GO;
        end
      end
      S_MUL_LO: begin
        if (a_done) begin
          state_d = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        if (a_done) begin
          state_d = S_MOVE;
        end
      end
      S_MOVE:   state_d = S_DIV_GO;
      S_LOAD: begin
        if (a_done) begin
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: state_d = S_DIV;
      S_DIV: begin
        if (a_done) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    areq.start = 1'b0;
    areq.op    = OP_MUL;
    a_opnd     = RAW_W'(raw_q);
    case (state_q)
      S_START: begin
        if (moving_q) begin
          areq.start = 1'b1;
          a_opnd     = RAW_W'(min_q);
        end else if (cmd_q == CMD_LOAD) begin
          areq.start = 1'b1;
          a_opnd     = RAW_W'(load_q);
        end
      end
      S_MUL_LO: begin
        areq.start = a_done;
        a_opnd     = RAW_W'(max_q);
      end
      S_DIV_GO: begin
        areq.start = 1'b1;
        areq.op    = OP_DIV;
      end
      default: begin
        areq.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    prior_ab_d  = prior_ab_q;
    raw_d       = raw_q;
    last_read_d = last_read_q;
    last_move_d = last_move_q;
    step_d      = step_q;
    moving_d    = moving_q;
    load_d      = load_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    det_w_d     = det_w_q;
    chg_w_d     = chg_w_q;
    res_pend_d  = res_pend_q;
    out_valid_d = out_valid_q;
    det_o_d     = det_o_q;
    chg_o_d     = chg_o_q;
    step_o_d    = step_o_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_pend_q && out_free) begin
      res_pend_d  = 1'b0;
      out_valid_d = 1'b1;
      det_o_d     = det_w_q;
      chg_o_d     = chg_w_q;
      step_o_d    = step_q;
    end

    if (accept) begin
      cmd_d    = cmd_e'(cmd_i);
      load_d   = load_value_i;
      step_d   = '0;
      moving_d = 1'b0;
      if (cmd_e'(cmd_i) == CMD_SAMPLE) begin
        prior_ab_d = {pin_b_i, pin_a_i};
        if (dir != 2'sd0) begin
          moving_d    = 1'b1;
          step_d      = step_new;
          last_move_d = time_ms_i;
        end
      end else if (cmd_e'(cmd_i) == CMD_CLEAR) begin
        raw_d       = '0;
        last_read_d = '0;
      end
    end

    case (state_q)
      S_MUL_LO: begin
        if (a_done) begin
          lo_d = a_result;
        end
      end
      S_MUL_HI: begin
        if (a_done) begin
          hi_d = a_result + RAW_W'(s_eff - STEPS_W'(1));
        end
      end
      S_MOVE: begin
        if (wrap_q) begin
          if (next_raw > hi_q) begin
            raw_d = lo_q;
          end else if (next_raw < lo_q) begin
            raw_d = hi_q;
          end else begin
            raw_d = next_raw;
          end
        end else begin
          if (next_raw > hi_q) begin
            raw_d = hi_q;
          end else if (next_raw < lo_q) begin
            raw_d = lo_q;
          end else begin
            raw_d = next_raw;
          end
        end
      end
      S_LOAD: begin
        if (a_done) begin
          raw_d = a_result;
        end
      end
      S_DIV: begin
        if (a_done) begin
          det_w_d    = det_new;
          chg_w_d    = '0;
          res_pend_d = 1'b1;
          if (cmd_q == CMD_READ) begin
            chg_w_d     = CHG_W'(det_new) - CHG_W'(last_read_q);
            last_read_d = det_new;
          end
        end
      end
      default: begin
        res_pend_d = res_pend_d;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= {1'b1, {(DET_W-1){1'b0}}};
      max_q       <= {1'b0, {(DET_W-1){1'b1}}};
      wrap_q      <= 1'b0;
      accel_q     <= 1'b0;
      steps_q     <= STEPS_RESET;
      prior_ab_q  <= '0;
      raw_q       <= '0;
      last_read_q <= '0;
      last_move_q <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prior_ab_q  <= prior_ab_d;
      raw_q       <= raw_d;
      last_read_q <= last_read_d;
      last_move_q <= last_move_d;
      res_pend_q  <= res_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_DETENT: min_q   <= cfg_wdata_i;
          CFG_MAX_DETENT: max_q   <= cfg_wdata_i;
          CFG_WRAP_MODE:  wrap_q  <= cfg_wdata_i[0];
          CFG_ACCEL_EN:   accel_q <= cfg_wdata_i[0];
          CFG_STEPS:      steps_q <= cfg_wdata_i[STEPS_W-1:0];
          default:        steps_q <= steps_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    step_q   <= step_d;
    moving_q <= moving_d;
    load_q   <= load_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    det_w_q  <= det_w_d;
    chg_w_q  <= chg_w_d;
    det_o_q  <= det_o_d;
    chg_o_q  <= chg_o_d;
    step_o_q <= step_o_d;
  end

  assign out_valid_o       = out_valid_q;
  assign detent_position_o = det_o_q;
  assign change_o          = chg_o_q;
  assign step_applied_o    = step_o_q;

endmodule
